>>> rtl/bjr_pkg.sv
// Shared types, codes and the character decoder for the bracket jump resolver.
package bjr_pkg;

  localparam int unsigned PROGRAM_DEPTH_DEF = 4096;
  localparam int unsigned NEST_DEPTH_DEF    = 256;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 1;

  // Commands carried on the input channel.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_CHAR   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // Result kinds.
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNMATCHED = 3'd1;
  localparam logic [2:0] ST_UNCLOSED  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_TOO_DEEP  = 3'd4;
  localparam logic [2:0] ST_BAD_INDEX = 3'd5;

  // Instruction opcodes.
  localparam logic [2:0] OP_ENTRY = 3'd0;
  localparam logic [2:0] OP_INC   = 3'd1;
  localparam logic [2:0] OP_MOVE  = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WRITE = 3'd4;
  localparam logic [2:0] OP_JUMP  = 3'd5;
  localparam logic [2:0] OP_JNZ   = 3'd6;
  localparam logic [2:0] OP_EXIT  = 3'd7;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  localparam logic signed [13:0] ARG_PLUS  = 14'sd1;
  localparam logic signed [13:0] ARG_MINUS = -14'sd1;
  localparam logic signed [13:0] ARG_ZERO  = 14'sd0;

  // One stored instruction.
  typedef struct packed {
    logic [2:0]         op;
    logic signed [13:0] arg;
    logic [15:0]        off;
  } instr_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         op;
    logic signed [13:0] arg;
  } decode_t;

  function automatic decode_t decode_char(input logic [7:0] c);
    decode_t d;
    d.valid = 1'b1;
    d.op    = OP_INC;
    d.arg   = ARG_PLUS;
    unique case (c)
      CH_PLUS:  d.op = OP_INC;
      CH_MINUS: begin d.op = OP_INC;  d.arg = ARG_MINUS; end
      CH_GT:    d.op = OP_MOVE;
      CH_LT:    begin d.op = OP_MOVE; d.arg = ARG_MINUS; end
      CH_COMMA: d.op = OP_READ;
      CH_DOT:   d.op = OP_WRITE;
      CH_OPEN:  begin d.op = OP_JUMP; d.arg = ARG_ZERO; end
      CH_CLOSE: begin d.op = OP_JNZ;  d.arg = ARG_ZERO; end
      default:  d.valid = 1'b0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/bracket_jump_resolver_top.sv
// Top level of the bracket jump resolver: decoder, bracket stack and instruction store.
//
//   Channel  Direction  Signals            Contents
//   in_      input      tdata, tuser       command, source byte, read index
//   out_     output     tdata, tuser       summary or instruction readout
//
// Every accepted transfer is taken in S_IDLE, which issues the memory reads, and
// is then worked on in S_EXEC. A closing bracket also passes through S_PATCH,
// because the instruction store has one write port and the matching opening
// jump is patched after the bracket's own instruction is written.
// Finish and read wait in their work cycle while an earlier result is not yet taken.
// Reset and clear need no clearing pass: the stores are undefined until written
// and slot 0 (the entry instruction) is supplied as a constant on readout.
module bracket_jump_resolver_top #(
  parameter int unsigned PROGRAM_DEPTH = bjr_pkg::PROGRAM_DEPTH_DEF,
  parameter int unsigned NEST_DEPTH    = bjr_pkg::NEST_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: source_char[7:0], read_index[19:8], zero fill.
  input  logic [bjr_pkg::IN_DATA_W-1:0]     in_tdata,
  // Fields from bit 0: cmd[1:0].
  input  logic [bjr_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: status[2:0], opcode[5:3], argument[19:6],
  // src_offset[35:20], instr_count[48:36], label_count[61:49], zero fill.
  output logic [bjr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Fields from bit 0: kind[0].
  output logic [bjr_pkg::OUT_USER_W-1:0]    out_tuser
);
  import bjr_pkg::*;

  // Address and counter widths that follow from the store depths.
  localparam int unsigned AW   = $clog2(PROGRAM_DEPTH);
  localparam int unsigned NSW  = $clog2(PROGRAM_DEPTH + 1);
  localparam int unsigned LW   = $clog2(PROGRAM_DEPTH + 3);
  localparam int unsigned SAW  = $clog2(NEST_DEPTH);
  localparam int unsigned SPW  = $clog2(NEST_DEPTH + 1);
  localparam int unsigned CMPW = (NSW > 12) ? NSW : 12;
  localparam int unsigned SEW  = AW + LW + 16;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_PATCH = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic [1:0]     cmd_r, cmd_nxt;
  logic [7:0]     char_r, char_nxt;
  logic [11:0]    idx_r, idx_nxt;

  logic [SPW-1:0] sp_r, sp_nxt;
  logic [NSW-1:0] next_slot_r, next_slot_nxt;
  logic [LW-1:0]  leader_r, leader_nxt;
  logic [15:0]    offset_r, offset_nxt;
  logic           prev_jump_r, prev_jump_nxt;
  logic [2:0]     err_r, err_nxt;
  logic           finished_r, finished_nxt;

  logic [AW-1:0]  patch_slot_r, patch_slot_nxt;
  logic [15:0]    patch_off_r, patch_off_nxt;
  logic [13:0]    patch_arg_r, patch_arg_nxt;

  logic           out_tvalid_r, out_tvalid_nxt;
  logic           out_load;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  // Instruction store: one write port, one registered read port.
  instr_t         imem [PROGRAM_DEPTH];
  logic           imem_we;
  logic [AW-1:0]  imem_wa;
  instr_t         imem_wd;
  logic           imem_re;
  logic [AW-1:0]  imem_ra;
  instr_t         imem_rd_r;

  // Open bracket stack: {slot, label after it, offset} per entry.
  logic [SEW-1:0] smem [NEST_DEPTH];
  logic           smem_we;
  logic [SAW-1:0] smem_wa;
  logic [SEW-1:0] smem_wd;
  logic           smem_re;
  logic [SAW-1:0] smem_ra;
  logic [SEW-1:0] smem_rd_r;

  logic           in_fire;
  logic           out_free;
  logic [CMPW-1:0] in_idx_ext;
  logic [CMPW-1:0] idx_ext;
  logic [SPW-1:0]  sp_m1;
  decode_t         dec;
  logic [LW-1:0]   leader_after_prev;
  logic [31:0]     own32, stk_label32, ns32, lc32;
  logic [AW-1:0]   stk_slot;
  logic [LW-1:0]   stk_label;
  logic [15:0]     stk_off;
  logic            bad_index;
  instr_t          readout;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign in_idx_ext = CMPW'(in_tdata[19:8]);
  assign idx_ext    = CMPW'(idx_r);
  assign sp_m1      = sp_r - SPW'(1);
  assign dec        = decode_char(char_r);

  // The reads are issued while the transfer is accepted; data is there in S_EXEC.
  assign imem_re = in_fire;
  assign imem_ra = in_idx_ext[AW-1:0];
  assign smem_re = in_fire;
  assign smem_ra = sp_m1[SAW-1:0];

  assign {stk_slot, stk_label, stk_off} = smem_rd_r;
  assign stk_label32 = 32'(stk_label);
  assign own32       = 32'(leader_r);
  assign ns32        = 32'(next_slot_nxt);
  assign lc32        = 32'(leader_nxt);

  assign leader_after_prev = prev_jump_r ? leader_r + LW'(1) : leader_r;

  assign bad_index = (idx_ext >= CMPW'(next_slot_r)) || (idx_ext >= CMPW'(PROGRAM_DEPTH));

  // Slot 0 is never written; its readout is always the entry instruction.
  always_comb begin
    if (idx_r == 12'd0) begin
      readout.op  = OP_ENTRY;
      readout.arg = ARG_PLUS;
      readout.off = 16'd0;
    end else begin
      readout = imem_rd_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    char_nxt       = char_r;
    idx_nxt        = idx_r;
    sp_nxt         = sp_r;
    next_slot_nxt  = next_slot_r;
    leader_nxt     = leader_r;
    offset_nxt     = offset_r;
    prev_jump_nxt  = prev_jump_r;
    err_nxt        = err_r;
    finished_nxt   = finished_r;
    patch_slot_nxt = patch_slot_r;
    patch_off_nxt  = patch_off_r;
    patch_arg_nxt  = patch_arg_r;
    imem_we        = 1'b0;
    imem_wa        = next_slot_r[AW-1:0];
    imem_wd.op     = dec.op;
    imem_wd.arg    = dec.arg;
    imem_wd.off    = offset_r;
    smem_we        = 1'b0;
    smem_wa        = sp_r[SAW-1:0];
    smem_wd        = {next_slot_r[AW-1:0], leader_after_prev, offset_r};
    out_load       = 1'b0;
    out_user_nxt   = KIND_SUMMARY;
    out_data_nxt   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_tuser[1:0];
          char_nxt  = in_tdata[7:0];
          idx_nxt   = in_tdata[19:8];
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (cmd_r)
          CMD_CLEAR: begin
            sp_nxt        = '0;
            next_slot_nxt = NSW'(1);
            leader_nxt    = LW'(1);
            offset_nxt    = 16'd0;
            prev_jump_nxt = 1'b0;
            err_nxt       = ST_OK;
            finished_nxt  = 1'b0;
            state_nxt     = S_IDLE;
          end

          CMD_CHAR: begin
            state_nxt = S_IDLE;
            if (!finished_r) begin
              if (offset_r != 16'hFFFF) begin
                offset_nxt = offset_r + 16'd1;
              end
              if (dec.valid && err_r == ST_OK) begin
                priority if (next_slot_r >= NSW'(PROGRAM_DEPTH - 1)) begin
                  err_nxt = ST_TOO_LONG;
                end else if (dec.op == OP_JNZ && sp_r == '0) begin
                  err_nxt = ST_UNMATCHED;
                end else if (dec.op == OP_JUMP && sp_r >= SPW'(NEST_DEPTH)) begin
                  err_nxt = ST_TOO_DEEP;
                end else begin
                  imem_we       = 1'b1;
                  next_slot_nxt = next_slot_r + NSW'(1);
                  prev_jump_nxt = (dec.op == OP_JUMP) || (dec.op == OP_JNZ);
                  if (dec.op == OP_JNZ) begin
                    // A closing bracket is a leader of its own; its label
                    // is written back into the opening jump in S_PATCH.
                    leader_nxt     = leader_r + LW'(1);
                    sp_nxt         = sp_m1;
                    imem_wd.arg    = stk_label32[13:0];
                    patch_slot_nxt = stk_slot;
                    patch_off_nxt  = stk_off;
                    patch_arg_nxt  = own32[13:0];
                    state_nxt      = S_PATCH;
                  end else begin
                    leader_nxt = leader_after_prev;
                    if (dec.op == OP_JUMP) begin
                      smem_we = 1'b1;
                      sp_nxt  = sp_r + SPW'(1);
                    end
                  end
                end
              end
            end
          end

          CMD_FINISH: begin
            if (out_free) begin
              if (!finished_r) begin
                if (err_r == ST_OK && sp_r != '0) begin
                  err_nxt = ST_UNCLOSED;
                end
                if (next_slot_r < NSW'(PROGRAM_DEPTH)) begin
                  imem_we       = 1'b1;
                  imem_wd.op    = OP_EXIT;
                  imem_wd.arg   = ARG_PLUS;
                  next_slot_nxt = next_slot_r + NSW'(1);
                end
                // One more label for the instruction after a trailing bracket,
                // one for the position just past the end.
                leader_nxt    = leader_r + (prev_jump_r ? LW'(2) : LW'(1));
                prev_jump_nxt = 1'b0;
                finished_nxt  = 1'b1;
              end
              out_load     = 1'b1;
              out_user_nxt = KIND_SUMMARY;
              out_data_nxt = {2'b00, lc32[12:0], ns32[12:0], 16'd0, 14'd0, OP_ENTRY, err_nxt};
              state_nxt    = S_IDLE;
            end
          end

          CMD_READ: begin
            if (out_free) begin
              out_load     = 1'b1;
              out_user_nxt = KIND_READOUT;
              if (bad_index) begin
                out_data_nxt = {2'b00, 13'd0, 13'd0, 16'd0, 14'd0, OP_ENTRY, ST_BAD_INDEX};
              end else begin
                out_data_nxt = {2'b00, 13'd0, 13'd0, readout.off, readout.arg,
                                readout.op, ST_OK};
              end
              state_nxt = S_IDLE;
            end
          end

          default: state_nxt = S_IDLE;
        endcase
      end

      S_PATCH: begin
        imem_we     = 1'b1;
        imem_wa     = patch_slot_r;
        imem_wd.op  = OP_JUMP;
        imem_wd.arg = patch_arg_r;
        imem_wd.off = patch_off_r;
        state_nxt   = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    out_tvalid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sp_r         <= '0;
      next_slot_r  <= NSW'(1);
      leader_r     <= LW'(1);
      offset_r     <= 16'd0;
      prev_jump_r  <= 1'b0;
      err_r        <= ST_OK;
      finished_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sp_r         <= sp_nxt;
      next_slot_r  <= next_slot_nxt;
      leader_r     <= leader_nxt;
      offset_r     <= offset_nxt;
      prev_jump_r  <= prev_jump_nxt;
      err_r        <= err_nxt;
      finished_r   <= finished_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    char_r       <= char_nxt;
    idx_r        <= idx_nxt;
    patch_slot_r <= patch_slot_nxt;
    patch_off_r  <= patch_off_nxt;
    patch_arg_r  <= patch_arg_nxt;
    if (out_load) begin
      out_tdata_r <= out_data_nxt;
      out_tuser_r <= out_user_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (imem_we) begin
      imem[imem_wa] <= imem_wd;
    end
    if (imem_re) begin
      imem_rd_r <= imem[imem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (smem_we) begin
      smem[smem_wa] <= smem_wd;
    end
    if (smem_re) begin
      smem_rd_r <= smem[smem_ra];
    end
  end

endmodule

>>> sim/tb_bracket_jump_resolver_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bracket jump resolver: predicts every summary and readout.
module tb_bracket_jump_resolver_top;
  import bjr_pkg::*;

  localparam int unsigned PROG_DEPTH = PROGRAM_DEPTH_DEF;
  localparam int unsigned NEST_LIMIT = NEST_DEPTH_DEF;
  // Cycles without any transfer on either channel before the run is abandoned. The
  // longest correct quiet stretch is the receiver hold-off plus the pending work.
  localparam int QUIET_LIMIT = 3000;
  // Length of the deliberate receiver hold-off that fills the block up.
  localparam int STALL_LEN   = 300;
  // Settling time after the last result, well beyond the work time of one transfer.
  localparam int END_SETTLE  = 20;
  localparam int PRINT_CAP   = 200;

  // One result as seen on the output channel, one field per member.
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [2:0]  opcode;
    logic [13:0] argument;
    logic [15:0] offset;
    logic [12:0] icount;
    logic [12:0] lcount;
  } reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  bracket_jump_resolver_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Summaries and readouts the resolver still owes, oldest first.
  reply_t reply_queue[$];

  int fail_count;
  int work_items;     // transfers that are not plain comment bytes
  int send_idle_pct;  // chance per cycle that the sender holds back
  int recv_idle_pct;  // chance per cycle that the receiver holds back
  bit stall_req;      // asks the receiver process for one long hold-off

  // Shadow copy of the resolver: instruction list, bracket stack and counters.
  logic [2:0]  prog_op  [PROG_DEPTH];
  int          prog_arg [PROG_DEPTH];
  logic [15:0] prog_off [PROG_DEPTH];
  int unsigned nest_slot  [NEST_LIMIT];
  int unsigned nest_label [NEST_LIMIT];
  int unsigned nest_sp;
  int unsigned fill_slot;
  int unsigned label_next;
  int unsigned byte_count;
  bit          after_branch;
  logic [2:0]  fault;
  bit          closed;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic note_failure(input string msg);
    if (fail_count < PRINT_CAP) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    end
  endtask

  // Command characters and the instruction each one becomes; anything else is a comment.
  function automatic bit decode_source(input logic [7:0] c, output logic [2:0] op,
                                       output int arg);
    op = OP_INC;
    arg = 1;
    decode_source = 1'b1;
    case (c)
      CH_PLUS:  ;
      CH_MINUS: arg = -1;
      CH_GT:    op = OP_MOVE;
      CH_LT: begin
        op = OP_MOVE;
        arg = -1;
      end
      CH_COMMA: op = OP_READ;
      CH_DOT:   op = OP_WRITE;
      CH_OPEN: begin
        op = OP_JUMP;
        arg = 0;
      end
      CH_CLOSE: begin
        op = OP_JNZ;
        arg = 0;
      end
      default:  decode_source = 1'b0;
    endcase
  endfunction

  function automatic void resolver_clear();
    prog_op[0]   = OP_ENTRY;
    prog_arg[0]  = 1;
    prog_off[0]  = 16'd0;
    nest_sp      = 0;
    fill_slot    = 1;
    label_next   = 1;
    byte_count   = 0;
    after_branch = 1'b0;
    fault        = ST_OK;
    closed       = 1'b0;
  endfunction

  function automatic void resolve_char(input logic [7:0] c);
    logic [2:0]  op;
    int          arg;
    int unsigned here;
    int unsigned own;
    here = byte_count;
    if (closed) return;
    if (byte_count < 65535) byte_count++;
    if (!decode_source(c, op, arg)) return;
    // The first error sticks and every later command character is dropped.
    if (fault != ST_OK) return;
    if (fill_slot >= PROG_DEPTH - 1) begin
      fault = ST_TOO_LONG;
      return;
    end
    if (op == OP_JNZ && nest_sp == 0) begin
      fault = ST_UNMATCHED;
      return;
    end
    if (op == OP_JUMP && nest_sp >= NEST_LIMIT) begin
      fault = ST_TOO_DEEP;
      return;
    end
    // The instruction after a bracket starts a block, and so does every closing bracket.
    if (after_branch) label_next++;
    if (op == OP_JNZ) begin
      if (!after_branch) label_next++;
      own = label_next - 1;
      nest_sp--;
      arg = int'(nest_label[nest_sp]);
      prog_arg[nest_slot[nest_sp]] = int'(own);
    end else if (op == OP_JUMP) begin
      nest_slot[nest_sp]  = fill_slot;
      nest_label[nest_sp] = label_next;
      nest_sp++;
    end
    prog_op[fill_slot]  = op;
    prog_arg[fill_slot] = arg;
    prog_off[fill_slot] = here[15:0];
    fill_slot++;
    after_branch = (op == OP_JUMP || op == OP_JNZ);
  endfunction

  function automatic void resolve_finish();
    if (closed) return;
    if (fault == ST_OK && nest_sp != 0) fault = ST_UNCLOSED;
    if (after_branch) label_next++;
    if (fill_slot < PROG_DEPTH) begin
      prog_op[fill_slot]  = OP_EXIT;
      prog_arg[fill_slot] = 1;
      prog_off[fill_slot] = byte_count[15:0];
      fill_slot++;
    end
    label_next++;
    after_branch = 1'b0;
    closed = 1'b1;
  endfunction

  // Updates the shadow state for one accepted command and queues the result it owes.
  function automatic void resolve_command(input logic [1:0] cmd, input logic [7:0] c,
                                          input logic [11:0] idx);
    reply_t r;
    r = '0;
    case (cmd)
      CMD_CLEAR: resolver_clear();
      CMD_CHAR:  resolve_char(c);
      CMD_FINISH: begin
        resolve_finish();
        r.kind   = KIND_SUMMARY;
        r.status = fault;
        r.icount = 13'(fill_slot);
        r.lcount = 13'(label_next);
        reply_queue = {reply_queue, r};
      end
      CMD_READ: begin
        r.kind = KIND_READOUT;
        if (idx >= fill_slot) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.status   = ST_OK;
          r.opcode   = prog_op[idx];
          r.argument = 14'(prog_arg[idx]);
          r.offset   = prog_off[idx];
        end
        reply_queue = {reply_queue, r};
      end
    endcase
  endfunction

  // Offers one transfer from the falling edge on, with random gaps, and holds it
  // until the rising edge at which the block takes it.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] c,
                           input logic [11:0] idx);
    logic [2:0] op;
    int         arg;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {4'b0000, idx, c};
    do @(posedge clk); while (!in_tready);
    resolve_command(cmd, c, idx);
    if (cmd != CMD_CHAR || decode_source(c, op, arg)) work_items++;
  endtask

  // Unused fields carry random bits so that every input bit below the zero fill moves.
  task automatic send_char(input logic [7:0] c);
    send_item(CMD_CHAR, c, 12'($urandom));
  endtask

  task automatic send_read(input logic [11:0] idx);
    send_item(CMD_READ, 8'($urandom), idx);
  endtask

  task automatic send_finish();
    send_item(CMD_FINISH, 8'($urandom), 12'($urandom));
  endtask

  task automatic send_clear();
    send_item(CMD_CLEAR, 8'($urandom), 12'($urandom));
  endtask

  // Reads mostly around the filled part of the list, now and then anywhere.
  task automatic send_near_read();
    int hi;
    hi = (fill_slot + 1 > PROG_DEPTH - 1) ? PROG_DEPTH - 1 : fill_slot + 1;
    if ($urandom_range(0, 7) == 0) begin
      send_read(12'($urandom));
    end else begin
      send_read(12'($urandom_range(0, hi)));
    end
  endtask

  function automatic logic [7:0] op_char(input int k);
    case (k)
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_GT;
      3:       return CH_LT;
      4:       return CH_COMMA;
      default: return CH_DOT;
    endcase
  endfunction

  // A random comment byte: command characters are moved into the upper half.
  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    logic [2:0] op;
    int         arg;
    c = 8'($urandom);
    if (decode_source(c, op, arg)) c = c ^ 8'h80;
    return c;
  endfunction

  task automatic wait_for_replies();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
  endtask

  // Every opcode, comment bytes at both ends of the range, a jump read before its
  // match arrives, bad indexes, a character after finish and a repeated finish.
  task automatic test_basic_program();
    send_clear();
    send_char(CH_PLUS);
    send_char(8'h00);
    send_char(CH_OPEN);
    send_read(12'd2);
    send_char(CH_MINUS);
    send_char(CH_CLOSE);
    send_char(CH_GT);
    send_char(CH_LT);
    send_char(CH_COMMA);
    send_char(CH_DOT);
    send_char(8'hFF);
    send_read(12'hFFF);
    send_finish();
    send_read(12'd0);
    send_read(12'd2);
    send_read(12'd4);
    send_read(12'd9);
    send_read(12'd10);
    send_char(CH_PLUS);
    send_finish();
    send_read(12'd9);
    wait_for_replies();
  endtask

  task automatic test_error_codes();
    // A closing bracket with nothing open; the opening bracket after it is dropped.
    send_clear();
    send_char(CH_PLUS);
    send_char(CH_CLOSE);
    send_char(CH_OPEN);
    send_finish();
    send_read(12'd1);
    send_read(12'd2);
    send_read(12'd3);
    // A bracket left open at finish.
    send_clear();
    send_char(CH_OPEN);
    send_char(CH_OPEN);
    send_char(CH_CLOSE);
    send_finish();
    for (int i = 1; i <= 5; i++) send_read(12'(i));
    // One opening bracket more than the stack holds; the too-deep code wins
    // over the unclosed one.
    send_clear();
    repeat (NEST_LIMIT + 1) send_char(CH_OPEN);
    send_char(CH_CLOSE);
    send_finish();
    send_read(12'(NEST_LIMIT));
    send_read(12'(NEST_LIMIT + 1));
    send_read(12'(NEST_LIMIT + 2));
    wait_for_replies();
  endtask

  // Mostly balanced programs with random content; some end with a stray closing
  // bracket or an open one, some skip the clear so the old program is finished again.
  task automatic test_random_programs(input int quota);
    int start;
    int depth;
    int len;
    int r;
    int mode;
    start = work_items;
    while (work_items - start < quota) begin
      if ($urandom_range(0, 7) != 0) send_clear();
      depth = 0;
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15 && depth < 30) begin
          send_char(CH_OPEN);
          depth++;
        end else if (r < 30 && depth > 0) begin
          send_char(CH_CLOSE);
          depth--;
        end else if (r < 40) begin
          send_char(noise_byte());
        end else if (r < 45) begin
          send_near_read();
        end else begin
          send_char(op_char($urandom_range(0, 5)));
        end
      end
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        send_char(CH_CLOSE);
      end else if (mode != 1) begin
        repeat (depth) send_char(CH_CLOSE);
      end
      send_finish();
      if ($urandom_range(0, 4) == 0) send_char(op_char($urandom_range(0, 5)));
      if ($urandom_range(0, 4) == 0) send_finish();
      repeat ($urandom_range(2, 6)) send_near_read();
    end
    wait_for_replies();
  endtask

  // The receiver stops for a long stretch while reads keep coming, so a result waits
  // inside the block and its input has to stall.
  task automatic test_backpressure();
    send_clear();
    repeat (12) send_char(op_char($urandom_range(0, 5)));
    send_char(CH_OPEN);
    send_char(CH_CLOSE);
    send_finish();
    stall_req = 1'b1;
    repeat (40) send_near_read();
    wait_for_replies();
  endtask

  // Receiver: ready changes on the falling edge, random or held low on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        stall_left = STALL_LEN;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Each result transfer is compared with the oldest prediction, field by field.
  always @(posedge clk) begin : check_replies
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind     = out_tuser[0];
      got.status   = out_tdata[2:0];
      got.opcode   = out_tdata[5:3];
      got.argument = out_tdata[19:6];
      got.offset   = out_tdata[35:20];
      got.icount   = out_tdata[48:36];
      got.lcount   = out_tdata[61:49];
      if (reply_queue.size() == 0) begin
        note_failure($sformatf("result with nothing pending: kind %0d status %0d",
                               got.kind, got.status));
      end else begin
        want = reply_queue.pop_front();
        check_field("kind", 16'(want.kind), 16'(got.kind));
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("opcode", 16'(want.opcode), 16'(got.opcode));
        check_field("argument", 16'(want.argument), 16'(got.argument));
        check_field("src_offset", want.offset, got.offset);
        check_field("instr_count", 16'(want.icount), 16'(got.icount));
        check_field("label_count", 16'(want.lcount), 16'(got.lcount));
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_bracket_jump_resolver_top failed");
    $finish;
  end

  initial begin : main
    fail_count    = 0;
    work_items    = 0;
    stall_req     = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 50;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = CMD_CLEAR;
    rst_n         = 1'b0;
    resolver_clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Sender idles lightly, receiver heavily.
    test_basic_program();
    test_error_codes();
    test_random_programs(130);

    // The other way round.
    send_idle_pct = 50;
    recv_idle_pct = 20;
    test_random_programs(130);

    // Neither side idles.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_programs(130);

    repeat (END_SETTLE) @(posedge clk);
    if (reply_queue.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", reply_queue.size()));
    end
    if (fail_count == 0) begin
      $display("tb_bracket_jump_resolver_top passed");
    end else begin
      $display("tb_bracket_jump_resolver_top failed");
    end
    $finish;
  end

endmodule
